/* rtl/core/vfc_pkg.sv */
`timescale 1ns / 1ps

package vfc_pkg;

    // Field widths of the command and result transactions
    localparam int SIZE_W    = 6;
    localparam int COORD_W   = 5;
    localparam int MASK_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd16;

    // Face bit positions in the mask
    localparam int FACE_TOP    = 5;
    localparam int FACE_BOTTOM = 4;
    localparam int FACE_LEFT   = 3;
    localparam int FACE_RIGHT  = 2;
    localparam int FACE_FRONT  = 1;
    localparam int FACE_BACK   = 0;

    // Cached row slots: center row and its four neighbor rows
    localparam int NUM_ROWS = 5;
    localparam logic [2:0] ROW_CENTER = 3'd0;
    localparam logic [2:0] ROW_UP     = 3'd1;
    localparam logic [2:0] ROW_DOWN   = 3'd2;
    localparam logic [2:0] ROW_FRONT  = 3'd3;
    localparam logic [2:0] ROW_BACK   = 3'd4;
    localparam logic [2:0] ROW_END    = 3'd5;

endpackage

/* rtl/core/voxel_face_cull_scan.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Signals                                   | Handshake
// command   | in        | i_cmd i_pos_x i_pos_y i_pos_z i_voxel_on  | start && !busy
// result    | out       | o_cell_x/y/z o_face_mask o_visible        | o_strobe, one cycle
//           |           | o_scan_done                               |
// config    | in        | i_cfg_index i_cfg_data                    | i_cfg_valid && o_cfg_ready
//
// An advance inside a row goes from accept straight to S_EVAL; the first cell of each row
// passes through S_LOAD first, since five row words (the cell's row and its four neighbor
// rows) are read one at a time through the single read port of the row memory. A write
// reads the row, then merges the bit and writes it back in S_WR. The result strobe comes in
// the cycle busy drops. After reset a clearing pass writes all 2^(2*clog2(min(MAX_DIM,32)))
// rows of the memory (1024 at the default), busy held high; config writes are taken throughout.
// The receiver cannot stall: each result shows for exactly one cycle.

module voxel_face_cull_scan #(
    parameter int MAX_DIM = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [vfc_pkg::COORD_W-1:0]       i_pos_x,
    input  logic [vfc_pkg::COORD_W-1:0]       i_pos_y,
    input  logic [vfc_pkg::COORD_W-1:0]       i_pos_z,
    input  logic                              i_voxel_on,
    // result channel
    output logic                              o_strobe,
    output logic [vfc_pkg::COORD_W-1:0]       o_cell_x,
    output logic [vfc_pkg::COORD_W-1:0]       o_cell_y,
    output logic [vfc_pkg::COORD_W-1:0]       o_cell_z,
    output logic [vfc_pkg::MASK_W-1:0]        o_face_mask,
    output logic                              o_visible,
    output logic                              o_scan_done,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vfc_pkg::SIZE_W-1:0]        i_cfg_data
);

    localparam int LIM   = (MAX_DIM < 32) ? MAX_DIM : 32;
    localparam int CW    = $clog2(LIM);
    localparam int RW    = 1 << CW;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [vfc_pkg::SIZE_W-1:0] LIM_V = vfc_pkg::SIZE_W'(LIM);
    localparam logic [vfc_pkg::SIZE_W-1:0] ONE_S = vfc_pkg::SIZE_W'(1);
    localparam logic [CW-1:0]              ONE_C = CW'(1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_EVAL,
        S_WR
    } t_state;

    t_state                      r_state;
    logic [AW-1:0]               r_clr;
    logic [2:0]                  r_k;
    logic [CW-1:0]               r_cx, r_cy, r_cz;
    logic [vfc_pkg::SIZE_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic [RW-1:0]               r_row [vfc_pkg::NUM_ROWS];
    logic [RW-1:0]               r_rd;
    logic [RW-1:0]               r_mem [DEPTH];
    logic [AW-1:0]               r_waddr;
    logic [CW-1:0]               r_wx;
    logic                        r_won;
    logic                        r_wr_ok;

    logic [vfc_pkg::SIZE_W-1:0]  ext_x, ext_y, ext_z;
    logic [AW-1:0]               mem_ra, mem_wa;
    logic [RW-1:0]               mem_wd, n_row;
    logic                        mem_we;
    logic [CW-1:0]               yp1, ym1, zp1, zm1;
    logic                        x_last, y_last, z_last;
    logic                        center, f_top, f_bottom, f_left, f_right, f_front, f_back;
    logic [vfc_pkg::MASK_W-1:0]  mask;
    logic                        accept, wr_in_grid, cfg_home;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Home the cursor on any write to a known register
    assign cfg_home = i_cfg_valid && o_cfg_ready &&
                      ((i_cfg_index == vfc_pkg::CFG_SIZE_X) ||
                       (i_cfg_index == vfc_pkg::CFG_SIZE_Y) ||
                       (i_cfg_index == vfc_pkg::CFG_SIZE_Z));

    // Clamp each size register to 1 .. LIM
    always_comb begin
        ext_x = (r_size_x == '0) ? ONE_S : ((r_size_x > LIM_V) ? LIM_V : r_size_x);
        ext_y = (r_size_y == '0) ? ONE_S : ((r_size_y > LIM_V) ? LIM_V : r_size_y);
        ext_z = (r_size_z == '0) ? ONE_S : ((r_size_z > LIM_V) ? LIM_V : r_size_z);
    end

    assign wr_in_grid = ({1'b0, i_pos_x} < ext_x) && ({1'b0, i_pos_y} < ext_y) &&
                        ({1'b0, i_pos_z} < ext_z);

    // Neighbor row coordinates; wrapped values are masked at evaluation
    assign yp1 = r_cy + ONE_C;
    assign ym1 = r_cy - ONE_C;
    assign zp1 = r_cz + ONE_C;
    assign zm1 = r_cz - ONE_C;

    // Select the row to read
    always_comb begin
        mem_ra = {r_cz, r_cy};
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd == vfc_pkg::CMD_WRITE) begin
                    mem_ra = {i_pos_z[CW-1:0], i_pos_y[CW-1:0]};
                end
            end
            S_LOAD: begin
                unique case (r_k)
                    vfc_pkg::ROW_UP:    mem_ra = {r_cz, yp1};
                    vfc_pkg::ROW_DOWN:  mem_ra = {r_cz, ym1};
                    vfc_pkg::ROW_FRONT: mem_ra = {zp1, r_cy};
                    vfc_pkg::ROW_BACK:  mem_ra = {zm1, r_cy};
                    default:            mem_ra = {r_cz, r_cy};
                endcase
            end
            default: mem_ra = {r_cz, r_cy};
        endcase
    end

    // Merge the written bit into the row just read
    always_comb begin
        n_row       = r_rd;
        n_row[r_wx] = r_won;
    end

    assign mem_we = (r_state == S_CLEAR) || ((r_state == S_WR) && r_wr_ok);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr : r_waddr;
    assign mem_wd = (r_state == S_CLEAR) ? '0 : n_row;

    // Row memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // Evaluate the cell at the cursor from the cached rows
    always_comb begin
        x_last   = !((vfc_pkg::SIZE_W'(r_cx) + ONE_S) < ext_x);
        y_last   = !((vfc_pkg::SIZE_W'(r_cy) + ONE_S) < ext_y);
        z_last   = !((vfc_pkg::SIZE_W'(r_cz) + ONE_S) < ext_z);
        center   = r_row[vfc_pkg::ROW_CENTER][r_cx];
        f_left   = (r_cx != '0) && r_row[vfc_pkg::ROW_CENTER][r_cx - ONE_C];
        f_right  = !x_last && r_row[vfc_pkg::ROW_CENTER][r_cx + ONE_C];
        f_top    = !y_last && r_row[vfc_pkg::ROW_UP][r_cx];
        f_bottom = (r_cy != '0) && r_row[vfc_pkg::ROW_DOWN][r_cx];
        f_front  = !z_last && r_row[vfc_pkg::ROW_FRONT][r_cx];
        f_back   = (r_cz != '0) && r_row[vfc_pkg::ROW_BACK][r_cx];
        mask     = '0;
        if (center) begin
            mask[vfc_pkg::FACE_TOP]    = !f_top;
            mask[vfc_pkg::FACE_BOTTOM] = !f_bottom;
            mask[vfc_pkg::FACE_LEFT]   = !f_left;
            mask[vfc_pkg::FACE_RIGHT]  = !f_right;
            mask[vfc_pkg::FACE_FRONT]  = !f_front;
            mask[vfc_pkg::FACE_BACK]   = !f_back;
        end
    end

    // Control, cursor, row cache and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cz        <= '0;
            r_size_x    <= vfc_pkg::SIZE_RESET;
            r_size_y    <= vfc_pkg::SIZE_RESET;
            r_size_z    <= vfc_pkg::SIZE_RESET;
            r_wr_ok     <= 1'b0;
            o_strobe    <= 1'b0;
            o_cell_x    <= '0;
            o_cell_y    <= '0;
            o_cell_z    <= '0;
            o_face_mask <= '0;
            o_visible   <= 1'b0;
            o_scan_done <= 1'b0;
        end else begin
            // Strobe the result in the cycle after evaluation or write-back
            o_strobe <= (r_state == S_EVAL) || (r_state == S_WR);
            unique case (r_state)
                // sweep every row to zero
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                // take the next transaction; the first row read issues now
                S_IDLE: begin
                    if (accept) begin
                        if (i_cmd == vfc_pkg::CMD_WRITE) begin
                            r_waddr <= {i_pos_z[CW-1:0], i_pos_y[CW-1:0]};
                            r_wx    <= i_pos_x[CW-1:0];
                            r_won   <= i_voxel_on;
                            r_wr_ok <= wr_in_grid;
                            r_state <= S_WR;
                        end else if (r_cx == '0) begin
                            r_k     <= vfc_pkg::ROW_UP;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                // capture the row read last cycle, issue the next
                S_LOAD: begin
                    r_row[r_k - 3'd1] <= r_rd;
                    r_k               <= r_k + 3'd1;
                    if (r_k == vfc_pkg::ROW_END) begin
                        r_state <= S_EVAL;
                    end
                end
                // report the cell
                S_EVAL: begin
                    o_cell_x    <= vfc_pkg::COORD_W'(r_cx);
                    o_cell_y    <= vfc_pkg::COORD_W'(r_cy);
                    o_cell_z    <= vfc_pkg::COORD_W'(r_cz);
                    o_face_mask <= mask;
                    o_visible   <= (mask != '0);
                    o_scan_done <= x_last && y_last && z_last;
                    r_state     <= S_IDLE;
                end
                // write back the merged row, return an all-zero result
                S_WR: begin
                    o_cell_x    <= '0;
                    o_cell_y    <= '0;
                    o_cell_z    <= '0;
                    o_face_mask <= '0;
                    o_visible   <= 1'b0;
                    o_scan_done <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase

            // Home the cursor on a write or a register write, else step it after evaluation
            if (cfg_home || (r_state == S_WR)) begin
                r_cx <= '0;
                r_cy <= '0;
                r_cz <= '0;
            end else if (r_state == S_EVAL) begin
                if (!x_last) begin
                    r_cx <= r_cx + ONE_C;
                end else begin
                    r_cx <= '0;
                    if (!y_last) begin
                        r_cy <= r_cy + ONE_C;
                    end else begin
                        r_cy <= '0;
                        if (!z_last) begin
                            r_cz <= r_cz + ONE_C;
                        end else begin
                            r_cz <= '0;
                        end
                    end
                end
            end

            // Load the size registers; unknown indexes drop
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    vfc_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data;
                    vfc_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data;
                    vfc_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/core/vfc_checker.sv */
`timescale 1ns / 1ps

module vfc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [vfc_pkg::MASK_W-1:0]    o_face_mask,
    input logic                          o_visible
);

    // An accepted transaction holds the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result only follows a busy cycle
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without preceding work");

    // A result shows once the block is ready again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while still busy");

    // Visible exactly when some face is exposed
    a_visible_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_visible == (o_face_mask != '0)))
        else $error("visible flag disagrees with face mask");

endmodule

bind voxel_face_cull_scan vfc_checker u_vfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_face_mask (o_face_mask),
    .o_visible   (o_visible)
);
